@@ hdl/mlsg_pkg.sv @@
package mlsg_pkg;

  localparam int IN_BITS  = 24;
  localparam int NUM_AXES = 4;

  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;
  localparam int AX_E = 3;

  localparam logic [7:0] DIR_X  = 8'd1;
  localparam logic [7:0] STEP_X = 8'd2;
  localparam logic [7:0] DIR_Z  = 8'd4;
  localparam logic [7:0] STEP_Z = 8'd8;
  localparam logic [7:0] DIR_Y  = 8'd16;
  localparam logic [7:0] STEP_Y = 8'd32;
  localparam logic [7:0] DIR_E  = 8'd64;
  localparam logic [7:0] STEP_E = 8'd128;

  typedef enum logic {
    OP_MOVE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [IN_BITS-1:0] x_target;
    logic signed [IN_BITS-1:0] y_target;
    logic signed [IN_BITS-1:0] z_target;
    logic signed [IN_BITS-1:0] e_delta;
    logic [NUM_AXES-1:0]       axis_mask;
  } item_t;

  typedef struct packed {
    logic [7:0] step_byte;
    logic [7:0] dir_byte;
    logic       moving;
    logic       last_step;
    logic       move_rejected;
  } result_t;

  function automatic logic [7:0] dir_code(input int ax);
    logic [7:0] c;
    case (ax)
      AX_X:    c = DIR_X;
      AX_Y:    c = DIR_Y;
      AX_Z:    c = DIR_Z;
      AX_E:    c = DIR_E;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] step_code(input int ax);
    logic [7:0] c;
    case (ax)
      AX_X:    c = STEP_X;
      AX_Y:    c = STEP_Y;
      AX_Z:    c = STEP_Z;
      AX_E:    c = STEP_E;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/multi_axis_line_step_generator_core.sv @@
// channel   direction  handshake         payload
// items     in         push / full       op, x_target, y_target, z_target, e_delta, axis_mask
// results   out        empty / pop       step_byte, dir_byte, moving, last_step, move_rejected
//
// A tick or a rejected move is handled in the execution stage as it is taken; a move that
// starts goes through ST_READY (magnitudes and directions), then ST_MAJOR (the major-count
// compare), which waits while the result queue is full. Each result is written to the
// result queue and shows on the outputs from there.
// Two-entry queues on both sides let input and output stall independently.
// Reset empties both queues, zeroes the positions and leaves the block idle.
module multi_axis_line_step_generator_core #(
  parameter int POSITION_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                op,
  input  logic signed [mlsg_pkg::IN_BITS-1:0] x_target,
  input  logic signed [mlsg_pkg::IN_BITS-1:0] y_target,
  input  logic signed [mlsg_pkg::IN_BITS-1:0] z_target,
  input  logic signed [mlsg_pkg::IN_BITS-1:0] e_delta,
  input  logic [mlsg_pkg::NUM_AXES-1:0]       axis_mask,
  output logic                                empty,
  input  logic                                pop,
  output logic [7:0]                          step_byte,
  output logic [7:0]                          dir_byte,
  output logic                                moving,
  output logic                                last_step,
  output logic                                move_rejected
);
  import mlsg_pkg::*;

  item_t   item;
  logic    avail;
  logic    take;
  logic    rq_full;
  logic    rq_push;
  result_t exec_res;
  result_t res;

  mlsg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .x_target  (x_target),
    .y_target  (y_target),
    .z_target  (z_target),
    .e_delta   (e_delta),
    .axis_mask (axis_mask),
    .avail     (avail),
    .item      (item),
    .take      (take)
  );

  mlsg_exec #(
    .POSITION_BITS (POSITION_BITS)
  ) u_exec (
    .clk      (clk),
    .rst      (rst),
    .in_avail (avail),
    .in_item  (item),
    .in_take  (take),
    .out_full (rq_full),
    .out_push (rq_push),
    .out_res  (exec_res)
  );

  mlsg_rq u_rq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (rq_push),
    .wr_res (exec_res),
    .q_full (rq_full),
    .empty  (empty),
    .pop    (pop),
    .res    (res)
  );

  assign step_byte     = res.step_byte;
  assign dir_byte      = res.dir_byte;
  assign moving        = res.moving;
  assign last_step     = res.last_step;
  assign move_rejected = res.move_rejected;

endmodule

@@ hdl/mlsg_front.sv @@
module mlsg_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 op,
  input  logic signed [mlsg_pkg::IN_BITS-1:0]  x_target,
  input  logic signed [mlsg_pkg::IN_BITS-1:0]  y_target,
  input  logic signed [mlsg_pkg::IN_BITS-1:0]  z_target,
  input  logic signed [mlsg_pkg::IN_BITS-1:0]  e_delta,
  input  logic [mlsg_pkg::NUM_AXES-1:0]        axis_mask,
  output logic                                 avail,
  output mlsg_pkg::item_t                      item,
  input  logic                                 take
);
  import mlsg_pkg::*;

  item_t      q [2];
  item_t      new_item;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr;
  logic       rd;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign wr    = push && !full;
  assign rd    = take && avail;
  assign item  = q[rd_ptr];

  always_comb begin
    new_item.op        = op ? OP_TICK : OP_MOVE;
    new_item.x_target  = x_target;
    new_item.y_target  = y_target;
    new_item.z_target  = z_target;
    new_item.e_delta   = e_delta;
    new_item.axis_mask = axis_mask;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/mlsg_exec.sv @@
module mlsg_exec #(
  parameter int POSITION_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_avail,
  input  mlsg_pkg::item_t   in_item,
  output logic              in_take,
  input  logic              out_full,
  output logic              out_push,
  output mlsg_pkg::result_t out_res
);
  import mlsg_pkg::*;

  localparam int D_W   = ((POSITION_BITS > IN_BITS) ? POSITION_BITS : IN_BITS) + 1;
  localparam int ACC_W = D_W + 1;

  typedef enum logic {
    ST_READY,
    ST_MAJOR
  } state_t;

  state_t                          state;
  logic                            busy;
  logic [7:0]                      dir_bits;
  logic signed [POSITION_BITS-1:0] pos_x;
  logic signed [POSITION_BITS-1:0] pos_y;
  logic signed [POSITION_BITS-1:0] pos_z;
  logic [D_W-1:0]                  mag [NUM_AXES];
  logic [ACC_W-1:0]                acc [NUM_AXES];
  logic [D_W-1:0]                  major;
  logic [D_W-1:0]                  steps_done;

  logic signed [D_W-1:0] tgt   [NUM_AXES];
  logic signed [D_W-1:0] cur   [NUM_AXES];
  logic signed [D_W-1:0] delta [NUM_AXES];
  logic [D_W-1:0]        mag_next [NUM_AXES];
  logic [7:0]            dir_next;
  logic [ACC_W-1:0]      sum [NUM_AXES];
  logic [ACC_W-1:0]      acc_next [NUM_AXES];
  logic [7:0]            step_bits;
  logic [D_W:0]          steps_inc;
  logic                  last;
  logic [D_W-1:0]        m01;
  logic [D_W-1:0]        m23;
  logic [D_W-1:0]        mx;
  logic                  is_move;
  logic                  start;

  assign is_move = (in_item.op == OP_MOVE);
  assign in_take = (state == ST_READY) && in_avail && !out_full;
  assign start   = in_take && is_move && !busy;

  // move setup, in ST_READY: deltas, magnitudes, direction bits
  always_comb begin
    tgt[AX_X] = D_W'(in_item.x_target);
    tgt[AX_Y] = D_W'(in_item.y_target);
    tgt[AX_Z] = D_W'(in_item.z_target);
    tgt[AX_E] = D_W'(in_item.e_delta);
    cur[AX_X] = D_W'(pos_x);
    cur[AX_Y] = D_W'(pos_y);
    cur[AX_Z] = D_W'(pos_z);
    cur[AX_E] = '0;
    dir_next  = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      delta[i] = tgt[i] - cur[i];
      if (!in_item.axis_mask[i]) begin
        mag_next[i] = '0;
      end else if (delta[i][D_W-1]) begin
        mag_next[i] = -delta[i];
        dir_next    = dir_next | dir_code(i);
      end else begin
        mag_next[i] = delta[i];
      end
    end
  end

  // per-tick accumulator update
  always_comb begin
    step_bits = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sum[i] = acc[i] + ACC_W'(mag[i]);
      if (sum[i] >= ACC_W'(major)) begin
        acc_next[i] = sum[i] - ACC_W'(major);
        step_bits   = step_bits | step_code(i);
      end else begin
        acc_next[i] = sum[i];
      end
    end
    steps_inc = (D_W+1)'(steps_done) + (D_W+1)'(1);
    last      = (steps_inc >= {1'b0, major});
  end

  // move setup, in ST_MAJOR: major count
  always_comb begin
    m01 = (mag[AX_X] > mag[AX_Y]) ? mag[AX_X] : mag[AX_Y];
    m23 = (mag[AX_Z] > mag[AX_E]) ? mag[AX_Z] : mag[AX_E];
    mx  = (m01 > m23) ? m01 : m23;
  end

  always_comb begin
    out_push              = 1'b0;
    out_res.step_byte     = dir_bits;
    out_res.dir_byte      = dir_bits;
    out_res.moving        = 1'b0;
    out_res.last_step     = 1'b0;
    out_res.move_rejected = 1'b0;
    if (state == ST_MAJOR) begin
      out_push       = !out_full;
      out_res.moving = (mx != '0);
    end else if (in_take && !start) begin
      out_push = 1'b1;
      if (is_move) begin
        out_res.moving        = 1'b1;
        out_res.move_rejected = 1'b1;
      end else if (busy) begin
        out_res.step_byte = dir_bits | step_bits;
        out_res.moving    = !last;
        out_res.last_step = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_READY;
      busy       <= 1'b0;
      dir_bits   <= '0;
      pos_x      <= '0;
      pos_y      <= '0;
      pos_z      <= '0;
      major      <= '0;
      steps_done <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        mag[i] <= '0;
        acc[i] <= '0;
      end
    end else begin
      case (state)
        ST_READY: begin
          if (start) begin
            state      <= ST_MAJOR;
            dir_bits   <= dir_next;
            steps_done <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
              mag[i] <= mag_next[i];
              acc[i] <= '0;
            end
            if (in_item.axis_mask[AX_X]) begin
              pos_x <= POSITION_BITS'(in_item.x_target);
            end
            if (in_item.axis_mask[AX_Y]) begin
              pos_y <= POSITION_BITS'(in_item.y_target);
            end
            if (in_item.axis_mask[AX_Z]) begin
              pos_z <= POSITION_BITS'(in_item.z_target);
            end
          end else if (in_take && !is_move && busy) begin
            for (int i = 0; i < NUM_AXES; i++) begin
              acc[i] <= acc_next[i];
            end
            steps_done <= steps_inc[D_W-1:0];
            busy       <= !last;
          end
        end
        ST_MAJOR: begin
          if (!out_full) begin
            state <= ST_READY;
            major <= mx;
            busy  <= (mx != '0);
          end
        end
        default: state <= ST_READY;
      endcase
    end
  end

endmodule

@@ hdl/mlsg_rq.sv @@
module mlsg_rq (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  mlsg_pkg::result_t wr_res,
  output logic              q_full,
  output logic              empty,
  input  logic              pop,
  output mlsg_pkg::result_t res
);
  import mlsg_pkg::*;

  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr;
  logic       rd;

  assign q_full = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign wr     = wr_en && !q_full;
  assign rd     = pop && !empty;
  assign res    = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= wr_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
